@@ rtl/assert_macros.svh @@
// assertion macros shared by rfc_seq, rfc_div and rfc_datapath
// expects signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

@@ rtl/rfc_pkg.sv @@
// package for the rectangle fill chunker: widths, microcode types and the microcode rom
// no dependencies
package rfc_pkg;

   // default screen and draw buffer geometry
   localparam int SCREEN_WIDTH_DEF  = 320;
   localparam int SCREEN_HEIGHT_DEF = 240;
   localparam int BUFFER_PIXELS_DEF = 10 * 1024 / 2;
   localparam int MAX_RESULTS       = 32;

   // transaction field widths
   localparam int COLOR_W   = 24;
   localparam int CLMN_W    = 9;
   localparam int ROWF_W    = 8;
   localparam int NPIX_OUT_W = 13;
   localparam int C565_W    = 16;

   // internal widths
   localparam int COL_W  = CLMN_W + 1;            // left + width
   localparam int ROW_W  = ROWF_W + 1;            // top + height
   localparam int PIX_W  = CLMN_W + ROWF_W;       // width * height, buffer cap
   localparam int EXT_W  = COL_W + 1;             // window ends before clamping
   localparam int CNT_W  = $clog2(MAX_RESULTS);
   localparam int STEP_W = 4;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL,
      OP_EMIT,
      OP_DIV_START,
      OP_ADV_DIV,
      OP_ADV_MID
   } op_type;

   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NO_REQ,
      CND_BAD,
      CND_OUT_BUSY,
      CND_LAST,
      CND_MID,
      CND_DIV_BUSY
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ucode_type;

   typedef struct packed {
      op_type op;
   } ctl_type;

   typedef struct packed {
      logic req_fire;
      logic bad;
      logic out_busy;
      logic last;
      logic mid;
      logic div_busy;
   } stat_type;

   // program addresses
   localparam logic [STEP_W-1:0] ST_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] ST_CHECK     = 4'd1;
   localparam logic [STEP_W-1:0] ST_EMIT      = 4'd2;
   localparam logic [STEP_W-1:0] ST_TEST_LAST = 4'd3;
   localparam logic [STEP_W-1:0] ST_TEST_MID  = 4'd4;
   localparam logic [STEP_W-1:0] ST_DIV_GO    = 4'd5;
   localparam logic [STEP_W-1:0] ST_DIV_WAIT  = 4'd6;
   localparam logic [STEP_W-1:0] ST_ADV_DIV   = 4'd7;
   localparam logic [STEP_W-1:0] ST_ADV_MID   = 4'd8;
   localparam logic [STEP_W-1:0] ST_LAST      = ST_ADV_MID;

   // microcode: on a true condition go to target, else fall through
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         ST_IDLE:      w = '{op: OP_LOAD,      cond: CND_NO_REQ,   target: ST_IDLE};
         ST_CHECK:     w = '{op: OP_MUL,       cond: CND_BAD,      target: ST_IDLE};
         ST_EMIT:      w = '{op: OP_EMIT,      cond: CND_OUT_BUSY, target: ST_EMIT};
         ST_TEST_LAST: w = '{op: OP_NOP,       cond: CND_LAST,     target: ST_IDLE};
         ST_TEST_MID:  w = '{op: OP_NOP,       cond: CND_MID,      target: ST_ADV_MID};
         ST_DIV_GO:    w = '{op: OP_DIV_START, cond: CND_NEVER,    target: ST_IDLE};
         ST_DIV_WAIT:  w = '{op: OP_NOP,       cond: CND_DIV_BUSY, target: ST_DIV_WAIT};
         ST_ADV_DIV:   w = '{op: OP_ADV_DIV,   cond: CND_ALWAYS,   target: ST_EMIT};
         ST_ADV_MID:   w = '{op: OP_ADV_MID,   cond: CND_ALWAYS,   target: ST_EMIT};
         default:      w = '{op: OP_NOP,       cond: CND_ALWAYS,   target: ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/rfc_if.sv @@
// request and response channel interfaces of the rectangle fill chunker
// depends on rfc_pkg
interface rfc_req_if
   import rfc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [COLOR_W-1:0]  color_rgb888;
   logic [CLMN_W-1:0]   left_col;
   logic [CLMN_W-1:0]   rect_width;
   logic [ROWF_W-1:0]   top_row;
   logic [ROWF_W-1:0]   rect_height;

   modport source (output valid, color_rgb888, left_col, rect_width, top_row, rect_height,
                   input ready);
   modport sink   (input valid, color_rgb888, left_col, rect_width, top_row, rect_height,
                   output ready);
endinterface

interface rfc_rsp_if
   import rfc_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CLMN_W-1:0]     win_col_first;
   logic [CLMN_W-1:0]     win_col_last;
   logic [ROWF_W-1:0]     win_row_first;
   logic [ROWF_W-1:0]     win_row_last;
   logic [NPIX_OUT_W-1:0] chunk_pixels;
   logic [C565_W-1:0]     color_rgb565;
   logic                  last_chunk;

   modport source (output valid, win_col_first, win_col_last, win_row_first, win_row_last,
                   chunk_pixels, color_rgb565, last_chunk, input ready);
   modport sink   (input valid, win_col_first, win_col_last, win_row_first, win_row_last,
                   chunk_pixels, color_rgb565, last_chunk, output ready);
endinterface

@@ rtl/rfc_seq.sv @@
// microcode sequencer: step counter, rom lookup and conditional jumps
// depends on rfc_pkg and assert_macros.svh
`include "assert_macros.svh"

module rfc_seq
   import rfc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctl_type  ctl
);

   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         uw;
   logic              take;

   assign uw = ucode_rom(step_ff);
   assign ctl.op = uw.op;

   always_comb begin
      unique case (uw.cond)
         CND_NEVER:    take = 1'b0;
         CND_ALWAYS:   take = 1'b1;
         CND_NO_REQ:   take = !stat.req_fire;
         CND_BAD:      take = stat.bad;
         CND_OUT_BUSY: take = stat.out_busy;
         CND_LAST:     take = stat.last;
         CND_MID:      take = stat.mid;
         CND_DIV_BUSY: take = stat.div_busy;
         default:      take = 1'b1;
      endcase
   end

   assign step_in = take ? uw.target : step_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   `ASSERT_NEVER(a_step_range, step_ff > ST_LAST, "step counter left the program")

endmodule

@@ rtl/rfc_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on rfc_pkg and assert_macros.svh
`include "assert_macros.svh"

module rfc_div
   import rfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PIX_W-1:0]  dividend,
   input  logic [CLMN_W-1:0] divisor,
   output logic              busy,
   output logic [PIX_W-1:0]  quot,
   output logic [CLMN_W-1:0] remain
);

   localparam int DCNT_W = $clog2(PIX_W + 1);

   logic [PIX_W-1:0]  quot_ff, quot_in;
   logic [CLMN_W-1:0] rem_ff, rem_in;
   logic [CLMN_W-1:0] dvs_ff, dvs_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [CLMN_W:0]   partial;
   logic              fits;

   assign busy   = (cnt_ff != '0);
   assign quot   = quot_ff;
   assign remain = rem_ff;

   assign partial = {rem_ff, quot_ff[PIX_W-1]};
   assign fits    = (partial >= {1'b0, dvs_ff});

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = DCNT_W'(PIX_W);
      end else if (busy) begin
         quot_in = {quot_ff[PIX_W-2:0], fits};
         rem_in  = fits ? CLMN_W'(partial - {1'b0, dvs_ff}) : partial[CLMN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   `ASSERT_NEVER(a_start_busy, start && busy, "divider restarted while running")

endmodule

@@ rtl/rfc_datapath.sv @@
// datapath: request registers, chunk arithmetic, position advance and output register
// depends on rfc_pkg, rfc_if, rfc_div and assert_macros.svh
`include "assert_macros.svh"

module rfc_datapath
   import rfc_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int BUFFER_PIXELS = BUFFER_PIXELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   output stat_type    stat,
   rfc_req_if.sink     req,
   rfc_rsp_if.source   rsp
);

   localparam logic [EXT_W-1:0] COL_MAX = EXT_W'(SCREEN_WIDTH - 1);
   localparam logic [EXT_W-1:0] ROW_MAX = EXT_W'(SCREEN_HEIGHT - 1);
   localparam logic [EXT_W-1:0] SW_LIM  = EXT_W'(SCREEN_WIDTH);
   localparam logic [EXT_W-1:0] SH_LIM  = EXT_W'(SCREEN_HEIGHT);
   localparam logic [PIX_W-1:0] BUF_LIM = PIX_W'(BUFFER_PIXELS);

   // request registers
   logic [C565_W-1:0] c565_ff;
   logic [CLMN_W-1:0] left_ff, w_ff;
   logic [ROWF_W-1:0] h_ff;
   // walk position
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PIX_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  n_ff;
   logic              mid_ff, last_ff;
   logic [PIX_W-1:0]  npix_ff;
   // output register
   logic              rsp_valid_ff;
   logic [CLMN_W-1:0] o_col_first_ff, o_col_last_ff;
   logic [ROWF_W-1:0] o_row_first_ff, o_row_last_ff;
   logic [C565_W-1:0] o_c565_ff;

   logic              req_fire, emit_fire, out_busy;
   logic [COL_W-1:0]  end_col, run, col_sum;
   logic              mid;
   logic [PIX_W-1:0]  npix_raw, npix, rem_next;
   logic [EXT_W-1:0]  col_last_full, row_last_full;
   logic [EXT_W-1:0]  col_last_c, row_last_c;
   logic              div_busy;
   logic [PIX_W-1:0]  div_quot;
   logic [CLMN_W-1:0] div_rem;

   assign req.ready = (ctl.op == OP_LOAD);
   assign req_fire  = req.valid && req.ready;
   assign out_busy  = rsp_valid_ff && !rsp.ready;
   assign emit_fire = (ctl.op == OP_EMIT) && !out_busy;

   // chunk arithmetic
   assign end_col  = COL_W'(left_ff) + COL_W'(w_ff);
   assign run      = end_col - col_ff;
   assign mid      = (col_ff != COL_W'(left_ff));
   assign npix_raw = mid ? PIX_W'(run) : rem_ff;
   assign npix     = (npix_raw > BUF_LIM) ? BUF_LIM : npix_raw;
   assign rem_next = rem_ff - npix;

   assign col_last_full = EXT_W'(col_ff) + EXT_W'(w_ff) - EXT_W'(1);
   assign row_last_full = EXT_W'(row_ff) + EXT_W'(h_ff) - EXT_W'(1);
   assign col_last_c    = (col_last_full > COL_MAX) ? COL_MAX : col_last_full;
   assign row_last_c    = (row_last_full > ROW_MAX) ? ROW_MAX : row_last_full;

   assign col_sum = col_ff + COL_W'(npix_ff);

   assign stat.req_fire = req_fire;
   assign stat.bad      = (EXT_W'(left_ff) + EXT_W'(w_ff) > SW_LIM)
                       || (EXT_W'(row_ff) + EXT_W'(h_ff) > SH_LIM)
                       || (w_ff == '0) || (h_ff == '0);
   assign stat.out_busy = out_busy;
   assign stat.last     = last_ff;
   assign stat.mid      = mid_ff;
   assign stat.div_busy = div_busy;

   rfc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.op == OP_DIV_START),
      .dividend (npix_ff),
      .divisor  (w_ff),
      .busy     (div_busy),
      .quot     (div_quot),
      .remain   (div_rem)
   );

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      rem_in = rem_ff;
      case (ctl.op)
         OP_LOAD: begin
            if (req_fire) begin
               col_in = COL_W'(req.left_col);
               row_in = ROW_W'(req.top_row);
            end
         end
         OP_MUL: begin
            rem_in = PIX_W'(w_ff) * PIX_W'(h_ff);
         end
         OP_EMIT: begin
            if (emit_fire) begin
               rem_in = rem_next;
            end
         end
         OP_ADV_MID: begin
            if (col_sum == end_col) begin
               col_in = COL_W'(left_ff);
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_sum;
            end
         end
         OP_ADV_DIV: begin
            col_in = COL_W'(left_ff) + COL_W'(div_rem);
            row_in = ROW_W'(PIX_W'(row_ff) + div_quot);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      row_ff <= row_in;
      rem_ff <= rem_in;
      if (req_fire) begin
         c565_ff <= {req.color_rgb888[23:19], req.color_rgb888[15:10], req.color_rgb888[7:3]};
         left_ff <= req.left_col;
         w_ff    <= req.rect_width;
         h_ff    <= req.rect_height;
         n_ff    <= '0;
      end
      if (emit_fire) begin
         n_ff           <= n_ff + 1'b1;
         mid_ff         <= mid;
         last_ff        <= (rem_next == '0) || (n_ff == CNT_W'(MAX_RESULTS - 1));
         npix_ff        <= npix;
         o_col_first_ff <= col_ff[CLMN_W-1:0];
         o_col_last_ff  <= col_last_c[CLMN_W-1:0];
         o_row_first_ff <= row_ff[ROWF_W-1:0];
         o_row_last_ff  <= row_last_c[ROWF_W-1:0];
         o_c565_ff      <= c565_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.win_col_first = o_col_first_ff;
   assign rsp.win_col_last  = o_col_last_ff;
   assign rsp.win_row_first = o_row_first_ff;
   assign rsp.win_row_last  = o_row_last_ff;
   assign rsp.chunk_pixels  = npix_ff[NPIX_OUT_W-1:0];
   assign rsp.color_rgb565  = o_c565_ff;
   assign rsp.last_chunk    = last_ff;

   `ASSERT_CLK(a_npix_range, rsp_valid_ff |-> (npix_ff != '0 && npix_ff <= BUF_LIM), "chunk size out of range")
   `ASSERT_CLK(a_rem_drops, emit_fire |=> (rem_ff < $past(rem_ff)), "chunk sent no pixels")

endmodule

@@ rtl/rect_fill_chunker_top.sv @@
// top level of the rectangle fill chunker: microcode sequencer plus datapath
// depends on rfc_pkg, rfc_if, rfc_seq and rfc_datapath
// flow: request load, size check and multiply, then emit once the output register is free
// chunks: last/mid tests, inline advance (mid-row) or divider start, wait, advance (left-edge)
// the final chunk ends after the last test; an empty or oversized request ends at the size check
// reset: synchronous, active high; returns the sequencer to idle and drops rsp valid
module rect_fill_chunker_top
   import rfc_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int BUFFER_PIXELS = BUFFER_PIXELS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rfc_req_if.sink   req_chan,
   rfc_rsp_if.source rsp_chan
);

   // control word from the rom and status back from the datapath
   ctl_type  ctl;
   stat_type stat;

   // sequencer: idle/load, size check and multiply, emit, then advance
   // either inline (mid-row chunk) or through the divider (left-edge chunk)
   rfc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   // datapath holds the request, walk position and the output register,
   // so a finished chunk waits there while the next one is worked out
   rfc_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .BUFFER_PIXELS (BUFFER_PIXELS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .stat  (stat),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

endmodule
